### design/hpe_pkg.sv
// hpe_pkg: widths, constants and shared types of the Horner polynomial evaluator.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package hpe_pkg;

  localparam int unsigned X_W            = 32;
  localparam int unsigned COEF_W         = 32;
  localparam int unsigned ACC_W          = 64;
  localparam int unsigned NUM_COEFS      = 8;
  localparam int unsigned COEF_IDX_W     = 3;
  localparam int unsigned CFG_INDEX_W    = 4;
  localparam int unsigned CFG_DATA_W     = 32;
  localparam int unsigned MAX_DEGREE_DEF = 7;

  typedef logic [NUM_COEFS-1:0][COEF_W-1:0] coef_vec_t;

  typedef struct packed {
    logic             valid;
    logic [X_W-1:0]   x;
    logic [ACC_W-1:0] acc;
  } stage_t;

  function automatic logic [ACC_W-1:0] sext_coef(input logic [COEF_W-1:0] c);
    sext_coef = {{(ACC_W - COEF_W){c[COEF_W-1]}}, c};
  endfunction

endpackage

### design/hpe_coef_regs.sv
// hpe_coef_regs: coefficient register file, written through the plain config port.
// Depends on hpe_pkg. Config index 0 holds the x^7 coefficient, index 7 the constant.
`timescale 1ns / 1ps

module hpe_coef_regs (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [hpe_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [hpe_pkg::CFG_DATA_W-1:0]    cfg_data,
  output hpe_pkg::coef_vec_t                coef_o
);

  hpe_pkg::coef_vec_t                 coef_r;
  logic [hpe_pkg::COEF_IDX_W-1:0]     deg_sel;
  logic                               idx_ok;

  assign idx_ok  = (cfg_index < hpe_pkg::CFG_INDEX_W'(hpe_pkg::NUM_COEFS));
  assign deg_sel = hpe_pkg::COEF_IDX_W'(hpe_pkg::NUM_COEFS - 1)
                   - cfg_index[hpe_pkg::COEF_IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r <= '0;
    end else if (cfg_we && idx_ok) begin
      coef_r[deg_sel] <= cfg_data[hpe_pkg::COEF_W-1:0];
    end
  end

  assign coef_o = coef_r;

endmodule

### design/hpe_step.sv
// hpe_step: one Horner step, acc * x + coef, as a multiply stage and an add stage.
// Depends on hpe_pkg. The 64x32 product is split into two partial products over the 32-bit halves of acc.
`timescale 1ns / 1ps

module hpe_step (
  input  logic                          clk,
  input  logic                          rst_n,
  input  hpe_pkg::stage_t               stage_i,
  input  logic [hpe_pkg::COEF_W-1:0]    coef_i,
  output hpe_pkg::stage_t               stage_o
);

  logic signed [hpe_pkg::X_W:0]         acc_lo_s;
  logic signed [hpe_pkg::X_W-1:0]       x_s;
  logic signed [hpe_pkg::ACC_W-1:0]     lo_prod;
  logic [hpe_pkg::X_W-1:0]              hi_prod;

  logic                                 mul_valid_r;
  logic [hpe_pkg::X_W-1:0]              mul_x_r;
  logic [hpe_pkg::ACC_W-1:0]            mul_lo_r;
  logic [hpe_pkg::X_W-1:0]              mul_hi_r;

  hpe_pkg::stage_t                      out_r;
  hpe_pkg::stage_t                      out_nxt;

  // low half of acc is unsigned, x is signed; high half only needs the low 32 bits
  assign acc_lo_s = $signed({1'b0, stage_i.acc[hpe_pkg::X_W-1:0]});
  assign x_s      = $signed(stage_i.x);
  assign lo_prod  = acc_lo_s * x_s;
  assign hi_prod  = stage_i.acc[hpe_pkg::ACC_W-1:hpe_pkg::X_W] * stage_i.x;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_valid_r <= 1'b0;
    end else begin
      mul_valid_r <= stage_i.valid;
    end
  end

  always_ff @(posedge clk) begin
    mul_x_r  <= stage_i.x;
    mul_lo_r <= lo_prod;
    mul_hi_r <= hi_prod;
  end

  always_comb begin
    out_nxt.valid = mul_valid_r;
    out_nxt.x     = mul_x_r;
    out_nxt.acc   = mul_lo_r + {mul_hi_r, {hpe_pkg::X_W{1'b0}}} + hpe_pkg::sext_coef(coef_i);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_r.valid <= 1'b0;
    end else begin
      out_r.valid <= out_nxt.valid;
    end
  end

  always_ff @(posedge clk) begin
    out_r.x   <= out_nxt.x;
    out_r.acc <= out_nxt.acc;
  end

  assign stage_o = out_r;

endmodule

### design/horner_polynomial_evaluator.sv
// horner_polynomial_evaluator: top level, coefficient file and Horner step chain.
// Depends on hpe_pkg, hpe_coef_regs and hpe_step.
//
// Usage:
//   Pulse start with a signed 32-bit sample on in_x_value; the word is taken
//   at every edge where start is high and busy is low. busy stays low, so a
//   new sample can enter on every cycle.
//   Each result appears for one cycle with out_valid high: out_x_echo holds
//   the sample, out_poly_value the 64-bit wrapping polynomial value.
//   Each sample passes one input register, then per Horner step one multiply
//   stage and one add stage.
//   Throughput is one word per cycle; the pipeline never stalls, since the
//   receiver takes every result in the cycle it is shown.
//   Coefficients are written through cfg_we / cfg_index / cfg_data; the user must
//   write them only while no sample is in flight, the block does not enforce this;
//   index 0 is the x^7 coefficient, index 7 the constant term, higher indexes are
//   dropped. Coefficients above MAX_DEGREE are kept but not used.
//   Synchronous reset clears all coefficients and every valid bit.
`timescale 1ns / 1ps

module horner_polynomial_evaluator #(
  parameter int unsigned MAX_DEGREE = hpe_pkg::MAX_DEGREE_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic signed [hpe_pkg::X_W-1:0]    in_x_value,
  output logic                              out_valid,
  output logic signed [hpe_pkg::X_W-1:0]    out_x_echo,
  output logic signed [hpe_pkg::ACC_W-1:0]  out_poly_value,
  input  logic                              cfg_we,
  input  logic [hpe_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [hpe_pkg::CFG_DATA_W-1:0]    cfg_data
);

  hpe_pkg::coef_vec_t  coef_vec;
  hpe_pkg::stage_t     chain [MAX_DEGREE+1];
  hpe_pkg::stage_t     in_r;

  hpe_coef_regs u_coef_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .coef_o    (coef_vec)
  );

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_r.valid <= 1'b0;
    end else begin
      in_r.valid <= start && !busy;
    end
  end

  // seed the accumulator with the leading coefficient in use
  always_ff @(posedge clk) begin
    in_r.x   <= in_x_value;
    in_r.acc <= hpe_pkg::sext_coef(coef_vec[MAX_DEGREE]);
  end

  assign chain[0] = in_r;

  for (genvar k = 0; k < MAX_DEGREE; k++) begin : g_step
    hpe_step u_step (
      .clk     (clk),
      .rst_n   (rst_n),
      .stage_i (chain[k]),
      .coef_i  (coef_vec[MAX_DEGREE-1-k]),
      .stage_o (chain[k+1])
    );
  end

  assign out_valid      = chain[MAX_DEGREE].valid;
  assign out_x_echo     = $signed(chain[MAX_DEGREE].x);
  assign out_poly_value = $signed(chain[MAX_DEGREE].acc);

endmodule
